FILE: rtl/nsmd_pkg.sv
// ----------------------------------------------------------------------------
// nsmd_pkg
// Shared types and constants for the new source address detector.
// ----------------------------------------------------------------------------
`default_nettype none

package nsmd_pkg;

    localparam int MAC_W       = 48;
    localparam int MAC_BYTES   = 6;
    localparam int HASH_BASE   = 13;
    // Six bytes folded with a base of 13 stay below 2^27.
    localparam int HASH_W      = 27;
    localparam int COUNT_W     = 13;
    localparam int COUNT_MAX   = 8191;

    localparam int DEF_BUCKETS = 1024;
    localparam int DEF_WAYS    = 4;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_UPDATE
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/new_source_mac_detector.sv
// ----------------------------------------------------------------------------
// new_source_mac_detector
// Learns source MAC addresses in a bucketed table and flags unseen ones.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  input    | in_valid, in_stall, source_mac            | in
//  output   | out_valid, out_stall, is_new, bucket_full,| out
//           | unique_count                              |
//
// An input transaction, when BUCKETS is a power of two, runs through accept
// and hash, bucket select with one registered read of the bucket row and fill
// count, then compare and write back. Otherwise the modulo adds a reciprocal
// multiplication before the bucket select.
// After reset the fill counts are cleared bucket by bucket; in_stall is
// high during that pass. A result waiting on out_stall holds its register
// while the next input transaction is taken and hashed.
// ----------------------------------------------------------------------------
`default_nettype none

module new_source_mac_detector
    import nsmd_pkg::*;
#(
    parameter int BUCKETS = DEF_BUCKETS,
    parameter int WAYS    = DEF_WAYS
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [MAC_W-1:0]   source_mac,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    is_new,
    output logic                    bucket_full,
    output logic [COUNT_W-1:0]      unique_count
);

    localparam int BIDX_W = $clog2(BUCKETS);
    localparam int FILL_W = $clog2(WAYS + 1);
    localparam int ROW_W  = WAYS * MAC_W;

    state_t              state_reg,   state_next;
    logic [BIDX_W-1:0]   clr_idx_reg, clr_idx_next;
    logic [BIDX_W-1:0]   bucket_reg,  bucket_next;
    logic [MAC_W-1:0]    mac_reg,     mac_next;
    logic [COUNT_W-1:0]  count_reg,   count_next;
    logic                out_valid_reg, out_valid_next;
    logic                is_new_reg,  is_new_next;
    logic                full_reg,    full_next;

    logic                hash_start;
    logic                hash_done;
    logic [BIDX_W-1:0]   hash_bucket;

    logic                rd_en;
    logic                row_we;
    logic [ROW_W-1:0]    row_rdata;
    logic [ROW_W-1:0]    row_wdata;
    logic                fill_we;
    logic [BIDX_W-1:0]   fill_waddr;
    logic [FILL_W-1:0]   fill_wdata;
    logic [FILL_W-1:0]   fill_rdata;

    logic                hit;
    logic                has_room;
    logic                out_free;

    nsmd_hash #(
        .BUCKETS (BUCKETS)
    ) u_hash (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (hash_start),
        .mac    (source_mac),
        .done   (hash_done),
        .bucket (hash_bucket)
    );

    nsmd_ram #(
        .WIDTH (ROW_W),
        .DEPTH (BUCKETS)
    ) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (bucket_reg),
        .wdata (row_wdata),
        .re    (rd_en),
        .raddr (hash_bucket),
        .rdata (row_rdata)
    );

    nsmd_ram #(
        .WIDTH (FILL_W),
        .DEPTH (BUCKETS)
    ) u_fill_ram (
        .clk   (clk),
        .we    (fill_we),
        .waddr (fill_waddr),
        .wdata (fill_wdata),
        .re    (rd_en),
        .raddr (hash_bucket),
        .rdata (fill_rdata)
    );

    // Only ways below the fill count hold written addresses.
    always_comb
    begin
        hit       = 1'b0;
        row_wdata = row_rdata;
        for (int w = 0; w < WAYS; w++)
        begin
            if ((FILL_W'(w) < fill_rdata) && (row_rdata[w*MAC_W +: MAC_W] == mac_reg))
            begin
                hit = 1'b1;
            end
            if (FILL_W'(w) == fill_rdata)
            begin
                row_wdata[w*MAC_W +: MAC_W] = mac_reg;
            end
        end
    end

    assign has_room = fill_rdata < FILL_W'(WAYS);
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        bucket_next    = bucket_reg;
        mac_next       = mac_reg;
        count_next     = count_reg;
        is_new_next    = is_new_reg;
        full_next      = full_reg;
        out_valid_next = out_valid_reg && out_stall;
        hash_start     = 1'b0;
        rd_en          = 1'b0;
        row_we         = 1'b0;
        fill_we        = 1'b0;
        fill_waddr     = bucket_reg;
        fill_wdata     = fill_rdata + 1'b1;

        unique case (state_reg)
            ST_CLEAR:
            begin
                fill_we      = 1'b1;
                fill_waddr   = clr_idx_reg;
                fill_wdata   = '0;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == BIDX_W'(BUCKETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    hash_start = 1'b1;
                    mac_next   = source_mac;
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                if (hash_done)
                begin
                    rd_en       = 1'b1;
                    bucket_next = hash_bucket;
                    state_next  = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    is_new_next    = !hit && has_room;
                    full_next      = !hit && !has_room;
                    if (!hit && has_room)
                    begin
                        row_we  = 1'b1;
                        fill_we = 1'b1;
                        if (count_reg != COUNT_W'(COUNT_MAX))
                        begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bucket_reg <= bucket_next;
        mac_reg    <= mac_next;
        is_new_reg <= is_new_next;
        full_reg   <= full_next;
    end

    // The count only moves when the output register is free, so it stays
    // with the result that is waiting.
    assign out_valid    = out_valid_reg;
    assign is_new       = is_new_reg;
    assign bucket_full  = full_reg;
    assign unique_count = count_reg;

endmodule

`default_nettype wire

FILE: rtl/nsmd_ram.sv
// ----------------------------------------------------------------------------
// nsmd_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module nsmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/nsmd_hash.sv
// ----------------------------------------------------------------------------
// nsmd_hash
// Folds the six address bytes into a hash and reduces it to a bucket index.
// ----------------------------------------------------------------------------
`default_nettype none

module nsmd_hash
    import nsmd_pkg::*;
#(
    parameter int BUCKETS = DEF_BUCKETS
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [MAC_W-1:0]           mac,
    output logic                            done,
    output logic [$clog2(BUCKETS)-1:0]      bucket
);

    localparam int  BW      = $clog2(BUCKETS);
    localparam bit  IS_POW2 = (BUCKETS & (BUCKETS - 1)) == 0;
    // The quotient comes from a rounded-up reciprocal of the bucket count,
    // which is exact for every hash below 2^HASH_W.
    localparam int  RSH     = HASH_W + BW;
    localparam int  PROD_W  = RSH + BW;
    localparam longint unsigned RECIP_L =
        ((64'd1 << RSH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
    localparam logic [PROD_W-1:0] RECIP = PROD_W'(RECIP_L);
    localparam logic [BW-1:0]     BMOD  = BW'(BUCKETS);

    logic              busy_reg,  busy_next;
    logic              step_reg,  step_next;
    logic [HASH_W-1:0] hash_reg,  hash_next;
    logic [BW-1:0]     quot_reg,  quot_next;
    logic [HASH_W-1:0] hash_val;
    logic [HASH_W-1:0] weight;
    logic [PROD_W-1:0] prod;
    logic [BW-1:0]     rem_low;
    logic              last;

    // Each byte is weighted by its power of the base, so the terms add up
    // side by side instead of in a chain.
    always_comb
    begin
        hash_val = '0;
        weight   = HASH_W'(1);
        for (int k = 0; k < MAC_BYTES; k++)
        begin
            hash_val = hash_val + HASH_W'(mac[k*8 +: 8]) * weight;
            weight   = weight * HASH_W'(HASH_BASE);
        end
    end

    // Only the low bits of the quotient matter: the remainder is below the
    // bucket count, so it is exact modulo 2^BW.
    assign prod    = PROD_W'(hash_reg) * RECIP;
    assign rem_low = hash_reg[BW-1:0] - quot_reg * BMOD;
    assign last    = IS_POW2 || step_reg;
    assign done    = busy_reg && last;
    assign bucket  = IS_POW2 ? hash_reg[BW-1:0] : rem_low;

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        hash_next = hash_reg;
        quot_next = quot_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = 1'b0;
            hash_next = hash_val;
        end
        else if (busy_reg)
        begin
            quot_next = prod[RSH +: BW];
            step_next = 1'b1;
            if (last)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hash_reg <= hash_next;
        quot_reg <= quot_next;
    end

endmodule

`default_nettype wire
